/* src/pss_pkg.sv */
// pss_pkg: shared widths, register indexes and types of the partial shuffle sampler
// used by the modulo unit, the pool memory and the top level
`default_nettype none

package pss_pkg;

    // widths that the item and register fields fix
    localparam int CFG_W   = 9;
    localparam int VALUE_W = 8;
    localparam int WORD_W  = 31;
    localparam int EPOCH_W = 8;

    // configuration register indexes
    localparam logic CFG_POOL_SIZE    = 1'b0;
    localparam logic CFG_SAMPLE_COUNT = 1'b1;

    typedef logic [CFG_W-1:0]   pss_count_t;
    typedef logic [VALUE_W-1:0] pss_value_t;
    typedef logic [EPOCH_W-1:0] pss_epoch_t;

endpackage

`default_nettype wire

/* src/partial_shuffle_sampler_core.sv */
// partial_shuffle_sampler_core: draws distinct pool values by a partial shuffle
// depends on pss_pkg, pss_mod_unit and pss_pool_mem
//
// Usage: each item on the s_ channel brings a random word (s_tdata) and a restart
// flag (s_tuser). Each item gives exactly one item on the m_ channel: the drawn
// value (m_tdata), last of run (m_tlast) and exhausted (m_tuser). The user writes
// pool_size, sample_count by cfg_we/cfg_index/cfg_data while idle (not enforced).
// Draw steps: a limit check, the one-bit-per-cycle remainder unit, two reads and
// two writes on the pool memory, and the output load. An exhausted draw goes from
// the limit check straight to the output load. One item is worked on at a time;
// s_tready is high only in idle.
// Restart opens a new run tag; every 255th restart runs a tag clearing pass over
// all POOL_DEPTH entries before its draw.
// Reset: registers go to pool_size 256, sample_count 25, draw count zero, and a
// clearing pass runs over all POOL_DEPTH entries of the pool memory, during which
// no item is accepted (configuration writes are taken).
// Stall: the result sits in an output register; the next item is accepted while
// it waits, and that item's result waits in turn until m_tready frees the register.
`default_nettype none

module partial_shuffle_sampler_core import pss_pkg::*; #(
    parameter int POOL_DEPTH   = 256,
    parameter int RANDOM_WIDTH = 31
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  pss_count_t  cfg_data,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [30:0] random_word, [31] zero fill
    input  logic        s_tuser,   // [0] restart
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output pss_value_t  m_tdata,   // [7:0] drawn_value
    output logic        m_tlast,   // last_of_run
    output logic        m_tuser    // [0] exhausted
);

    localparam int ADDR_W  = $clog2(POOL_DEPTH);
    localparam int DIV_W   = (RANDOM_WIDTH < WORD_W) ? RANDOM_WIDTH : WORD_W;
    localparam int CAP_INT = (POOL_DEPTH < (2**CFG_W - 1)) ? POOL_DEPTH : (2**CFG_W - 1);
    localparam pss_count_t        DEPTH_CAP   = CFG_W'(CAP_INT);
    localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(POOL_DEPTH - 1);
    localparam pss_epoch_t        EPOCH_MAX   = '1;
    localparam pss_epoch_t        EPOCH_FIRST = EPOCH_W'(1);
    localparam pss_epoch_t        EPOCH_CLEAR = '0;
    localparam pss_count_t        POOL_SIZE_RESET    = CFG_W'(256);
    localparam pss_count_t        SAMPLE_COUNT_RESET = CFG_W'(25);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_SWEEP   = 4'd1;
    localparam logic [3:0] ST_CHECK   = 4'd2;
    localparam logic [3:0] ST_DIV     = 4'd3;
    localparam logic [3:0] ST_RD_PICK = 4'd4;
    localparam logic [3:0] ST_RD_LAST = 4'd5;
    localparam logic [3:0] ST_WR_PICK = 4'd6;
    localparam logic [3:0] ST_WR_LAST = 4'd7;
    localparam logic [3:0] ST_OUT     = 4'd8;

    logic [3:0]        state_reg, state_next;
    logic [ADDR_W-1:0] sweep_addr_reg, sweep_addr_next;
    logic              sweep_item_reg, sweep_item_next;
    pss_epoch_t        epoch_reg, epoch_next;
    pss_count_t        pool_size_reg, pool_size_next;
    pss_count_t        sample_count_reg, sample_count_next;
    pss_count_t        draws_reg, draws_next;
    logic [DIV_W-1:0]  word_reg, word_next;
    logic [ADDR_W-1:0] pick_reg, pick_next;
    logic [ADDR_W-1:0] last_idx_reg, last_idx_next;
    pss_value_t        picked_reg, picked_next;
    logic              res_last_reg, res_last_next;
    logic              res_exh_reg, res_exh_next;
    logic              m_tvalid_reg, m_tvalid_next;
    pss_value_t        m_tdata_reg, m_tdata_next;
    logic              m_tlast_reg, m_tlast_next;
    logic              m_tuser_reg, m_tuser_next;

    pss_count_t        eff_pool;
    pss_count_t        run_limit;
    pss_count_t        remaining;
    pss_count_t        draws_inc;
    logic              out_free;
    logic              in_accept;
    logic              div_start;
    logic              div_done;
    pss_count_t        div_rem;
    logic              mem_wr_en;
    logic [ADDR_W-1:0] mem_wr_addr;
    pss_epoch_t        mem_wr_tag;
    pss_value_t        mem_wr_value;
    logic [ADDR_W-1:0] mem_rd_addr;
    pss_epoch_t        mem_rd_tag;
    pss_value_t        mem_rd_value;
    logic              rd_hit;
    logic [ADDR_W-1:0] rd_ident;
    pss_value_t        rd_resolved;

    // run limit from the current registers
    assign eff_pool  = (pool_size_reg > DEPTH_CAP) ? DEPTH_CAP : pool_size_reg;
    assign run_limit = (sample_count_reg < eff_pool) ? sample_count_reg : eff_pool;
    assign remaining = eff_pool - draws_reg;
    assign draws_inc = draws_reg + CFG_W'(1);

    // handshakes
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign div_start = (state_reg == ST_CHECK) && (draws_reg < run_limit);

    // an entry with a stale tag reads as its own index
    assign mem_rd_addr = (state_reg == ST_RD_LAST) ? last_idx_reg : pick_reg;
    assign rd_ident    = (state_reg == ST_WR_PICK) ? last_idx_reg : pick_reg;
    assign rd_hit      = (mem_rd_tag == epoch_reg);
    assign rd_resolved = rd_hit ? mem_rd_value : VALUE_W'(rd_ident);

    // draw sequencing
    always_comb begin
        state_next        = state_reg;
        sweep_addr_next   = sweep_addr_reg;
        sweep_item_next   = sweep_item_reg;
        epoch_next        = epoch_reg;
        pool_size_next    = pool_size_reg;
        sample_count_next = sample_count_reg;
        draws_next        = draws_reg;
        word_next         = word_reg;
        pick_next         = pick_reg;
        last_idx_next     = last_idx_reg;
        picked_next       = picked_reg;
        res_last_next     = res_last_reg;
        res_exh_next      = res_exh_reg;
        m_tvalid_next     = m_tvalid_reg;
        m_tdata_next      = m_tdata_reg;
        m_tlast_next      = m_tlast_reg;
        m_tuser_next      = m_tuser_reg;

        if (cfg_we) begin
            case (cfg_index)
                CFG_POOL_SIZE:    pool_size_next    = cfg_data;
                CFG_SAMPLE_COUNT: sample_count_next = cfg_data;
                default: ;
            endcase
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    word_next  = s_tdata[DIV_W-1:0];
                    state_next = ST_CHECK;
                    if (s_tuser) begin
                        draws_next = '0;
                        if (epoch_reg == EPOCH_MAX) begin
                            epoch_next      = EPOCH_FIRST;
                            sweep_addr_next = '0;
                            sweep_item_next = 1'b1;
                            state_next      = ST_SWEEP;
                        end else begin
                            epoch_next = epoch_reg + 1'b1;
                        end
                    end
                end
            end
            ST_SWEEP: begin
                sweep_addr_next = sweep_addr_reg + 1'b1;
                if (sweep_addr_reg == LAST_ADDR) begin
                    state_next = sweep_item_reg ? ST_CHECK : ST_IDLE;
                end
            end
            ST_CHECK: begin
                if (draws_reg >= run_limit) begin
                    picked_next   = '0;
                    res_last_next = 1'b0;
                    res_exh_next  = 1'b1;
                    state_next    = ST_OUT;
                end else begin
                    last_idx_next = ADDR_W'(remaining - CFG_W'(1));
                    res_exh_next  = 1'b0;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    pick_next  = ADDR_W'(div_rem);
                    state_next = ST_RD_PICK;
                end
            end
            ST_RD_PICK: begin
                state_next = ST_RD_LAST;
            end
            ST_RD_LAST: begin
                picked_next = rd_resolved;
                state_next  = ST_WR_PICK;
            end
            ST_WR_PICK: begin
                state_next = ST_WR_LAST;
            end
            ST_WR_LAST: begin
                draws_next    = draws_inc;
                res_last_next = (draws_inc == sample_count_reg);
                state_next    = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = picked_reg;
                    m_tlast_next  = res_last_reg;
                    m_tuser_next  = res_exh_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // pool memory write port: clearing pass and the two swap writes
    always_comb begin
        mem_wr_en    = 1'b0;
        mem_wr_addr  = pick_reg;
        mem_wr_tag   = epoch_reg;
        mem_wr_value = rd_resolved;
        case (state_reg)
            ST_SWEEP: begin
                mem_wr_en    = 1'b1;
                mem_wr_addr  = sweep_addr_reg;
                mem_wr_tag   = EPOCH_CLEAR;
                mem_wr_value = '0;
            end
            ST_WR_PICK: begin
                mem_wr_en    = 1'b1;
                mem_wr_addr  = pick_reg;
                mem_wr_value = rd_resolved;
            end
            ST_WR_LAST: begin
                mem_wr_en    = 1'b1;
                mem_wr_addr  = last_idx_reg;
                mem_wr_value = picked_reg;
            end
            default: ;
        endcase
    end

    // control and register state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_SWEEP;
            sweep_addr_reg   <= '0;
            sweep_item_reg   <= 1'b0;
            epoch_reg        <= EPOCH_FIRST;
            pool_size_reg    <= POOL_SIZE_RESET;
            sample_count_reg <= SAMPLE_COUNT_RESET;
            draws_reg        <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            state_reg        <= state_next;
            sweep_addr_reg   <= sweep_addr_next;
            sweep_item_reg   <= sweep_item_next;
            epoch_reg        <= epoch_next;
            pool_size_reg    <= pool_size_next;
            sample_count_reg <= sample_count_next;
            draws_reg        <= draws_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        word_reg     <= word_next;
        pick_reg     <= pick_next;
        last_idx_reg <= last_idx_next;
        picked_reg   <= picked_next;
        res_last_reg <= res_last_next;
        res_exh_reg  <= res_exh_next;
        m_tdata_reg  <= m_tdata_next;
        m_tlast_reg  <= m_tlast_next;
        m_tuser_reg  <= m_tuser_next;
    end

    pss_mod_unit #(
        .DVD_W (DIV_W)
    ) u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (word_reg),
        .divisor   (remaining),
        .done      (div_done),
        .remainder (div_rem)
    );

    pss_pool_mem #(
        .DEPTH  (POOL_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_pool (
        .aclk     (aclk),
        .wr_en    (mem_wr_en),
        .wr_addr  (mem_wr_addr),
        .wr_tag   (mem_wr_tag),
        .wr_value (mem_wr_value),
        .rd_addr  (mem_rd_addr),
        .rd_tag   (mem_rd_tag),
        .rd_value (mem_rd_value)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTH
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser)))
        else $error("result item changed while stalled");
    a_exhausted_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> ((m_tdata == '0) && !m_tlast))
        else $error("exhausted item carries a value");
    a_draws_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        draws_reg <= DEPTH_CAP)
        else $error("draw count beyond the pool");
    a_pick_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RD_PICK) |-> (pick_reg <= last_idx_reg))
        else $error("pick beyond the last remaining entry");
`endif

endmodule

`default_nettype wire

/* src/pss_mod_unit.sv */
// pss_mod_unit: restoring remainder unit, one dividend bit per cycle
// depends on pss_pkg for the count type
`default_nettype none

module pss_mod_unit import pss_pkg::*; #(
    parameter int DVD_W = 31
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  pss_count_t       divisor,
    output logic             done,
    output pss_count_t       remainder
);

    localparam int CNT_W = $clog2(DVD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] dvd_reg, dvd_next;
    pss_count_t       dsr_reg, dsr_next;
    pss_count_t       rem_reg, rem_next;
    logic [CFG_W:0]   trial;
    logic [CFG_W:0]   diff;
    logic             fits;

    // one restoring step
    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (start) begin
            run_next = 1'b1;
            cnt_next = CNT_LAST;
            dvd_next = dividend;
            dsr_next = divisor;
            rem_next = '0;
        end else if (run_reg) begin
            rem_next = fits ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            if (cnt_reg == '0) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operand and remainder registers
    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

`ifndef SYNTH
    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (rem_reg < dsr_reg))
        else $error("remainder not below divisor");
    a_no_restart_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !run_reg)
        else $error("start while a reduction runs");
    a_done_single: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg)
        else $error("done held longer than one cycle");
`endif

endmodule

`default_nettype wire

/* src/pss_pool_mem.sv */
// pss_pool_mem: pool table with a run tag per entry, one write and one registered read port
// depends on pss_pkg for the value and tag types
`default_nettype none

module pss_pool_mem import pss_pkg::*; #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  pss_epoch_t        wr_tag,
    input  pss_value_t        wr_value,
    input  logic [ADDR_W-1:0] rd_addr,
    output pss_epoch_t        rd_tag,
    output pss_value_t        rd_value
);

    logic [EPOCH_W+VALUE_W-1:0] mem_array [DEPTH];
    logic [EPOCH_W+VALUE_W-1:0] rd_word_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= {wr_tag, wr_value};
        end
    end

    // read port, registered
    always_ff @(posedge aclk) begin
        rd_word_reg <= mem_array[rd_addr];
    end

    assign rd_tag   = rd_word_reg[EPOCH_W+VALUE_W-1:VALUE_W];
    assign rd_value = rd_word_reg[VALUE_W-1:0];

endmodule

`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps
// testbench: self-checking stream test of partial_shuffle_sampler_core
// holds its own shuffle predictor, a queued item driver and a result monitor
// depends on pss_pkg and the sampler RTL

module testbench;
    import pss_pkg::*;

    localparam int POOL_ENTRIES = 256;
    localparam int ITEM_TARGET  = 900;
    localparam int LONG_HOLD    = 400;
    localparam int STORM_ITEMS  = 270;

    typedef struct packed {
        logic              restart;
        logic [WORD_W-1:0] word;
    } draw_req_t;

    typedef struct packed {
        pss_value_t value;
        logic       last;
        logic       exhausted;
    } draw_result_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = CFG_POOL_SIZE;
    pss_count_t  cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    pss_value_t  m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    partial_shuffle_sampler_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // shadow of the block state for prediction
    pss_count_t  pool_size_reg    = 9'd256;
    pss_count_t  sample_count_reg = 9'd25;
    pss_count_t  draw_count       = '0;
    pss_value_t  pool_tab  [POOL_ENTRIES];
    bit          pool_mark [POOL_ENTRIES];

    draw_req_t    pending_draws[$];
    draw_result_t predicted_draws[$];
    draw_result_t want_draw;

    int unsigned s_accepts = 0;
    int unsigned s_taken   = 0;
    int unsigned m_accepts = 0;
    int unsigned m_taken   = 0;
    int unsigned queued_total = 0;
    int unsigned mismatches   = 0;
    int unsigned send_idle_max = 0;
    int unsigned recv_idle_max = 0;
    int unsigned send_gap      = 0;
    int unsigned stall_left    = 0;
    bit          have_item = 1'b0;
    bit          hold_req  = 1'b0;
    bit          hold_seen = 1'b0;
    draw_req_t   cur_req;

    initial begin
        forever #1 aclk = ~aclk;
    end

    // run limit
    initial begin
        #1000000;
        $display("CHECK FAILED");
        $finish;
    end

    // unwritten entries read as their own index
    function automatic pss_value_t pool_get(int unsigned idx);
        return pool_mark[idx] ? pool_tab[idx] : pss_value_t'(idx);
    endfunction

    function automatic void pool_put(int unsigned idx, pss_value_t v);
        pool_tab[idx]  = v;
        pool_mark[idx] = 1'b1;
    endfunction

    function automatic int unsigned run_limit();
        int unsigned eff_pool;
        eff_pool = (pool_size_reg > POOL_ENTRIES) ? POOL_ENTRIES : pool_size_reg;
        return (sample_count_reg < eff_pool) ? sample_count_reg : eff_pool;
    endfunction

    // one partial shuffle step: pick, emit, swap with last remaining entry
    function automatic draw_result_t shuffle_draw(logic [WORD_W-1:0] word, logic restart);
        draw_result_t res;
        int unsigned  eff_pool, remaining, pick, last_idx;
        pss_value_t   picked;
        if (restart) begin
            foreach (pool_mark[i]) pool_mark[i] = 1'b0;
            draw_count = '0;
        end
        res = '0;
        if (draw_count >= run_limit()) begin
            res.exhausted = 1'b1;
            return res;
        end
        eff_pool  = (pool_size_reg > POOL_ENTRIES) ? POOL_ENTRIES : pool_size_reg;
        remaining = eff_pool - draw_count;
        pick      = word % remaining;
        last_idx  = remaining - 1;
        picked    = pool_get(pick);
        pool_put(pick, pool_get(last_idx));
        pool_put(last_idx, picked);
        draw_count = draw_count + 1'b1;
        res.value = picked;
        res.last  = (draw_count == sample_count_reg);
        return res;
    endfunction

    // random word with extra weight on the extremes
    function automatic logic [WORD_W-1:0] rand_word();
        logic [31:0] raw;
        raw = $urandom;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return WORD_W'($urandom_range(0, 600));
            default: return raw[WORD_W-1:0];
        endcase
    endfunction

    function automatic int unsigned pick_idle();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 2;
            default: return 18;
        endcase
    endfunction

    // handshakes, prediction and checking at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predicted_draws.push_back(shuffle_draw(s_tdata[WORD_W-1:0], s_tuser));
                s_accepts++;
            end
            if (m_tvalid && m_tready) begin
                m_accepts++;
                if (predicted_draws.size() == 0) begin
                    $error("unexpected result item: drawn_value %0d", m_tdata);
                    mismatches++;
                end else begin
                    want_draw = predicted_draws.pop_front();
                    if (m_tdata !== want_draw.value) begin
                        $error("drawn_value: expected %0d, actual %0d", want_draw.value, m_tdata);
                        mismatches++;
                    end
                    if (m_tlast !== want_draw.last) begin
                        $error("last_of_run: expected %0d, actual %0d", want_draw.last, m_tlast);
                        mismatches++;
                    end
                    if (m_tuser !== want_draw.exhausted) begin
                        $error("exhausted: expected %0d, actual %0d",
                               want_draw.exhausted, m_tuser);
                        mismatches++;
                    end
                end
            end
        end
    end

    // item driver: pops pending items, waits a random gap, holds until taken
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            have_item = 1'b0;
            s_taken   = s_accepts;
        end else begin
            if (have_item && s_accepts != s_taken) begin
                s_taken   = s_accepts;
                have_item = 1'b0;
            end
            if (!have_item && pending_draws.size() != 0) begin
                cur_req   = pending_draws.pop_front();
                have_item = 1'b1;
                send_gap  = $urandom_range(0, send_idle_max);
            end
            if (have_item && send_gap == 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {1'b0, cur_req.word};
                s_tuser  <= cur_req.restart;
            end else begin
                if (send_gap > 0) send_gap--;
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver: random stall after each item, one long hold on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            stall_left = 0;
            m_taken    = m_accepts;
        end else begin
            if (m_accepts != m_taken) begin
                m_taken    = m_accepts;
                stall_left = $urandom_range(0, recv_idle_max);
            end
            if (hold_req != hold_seen) begin
                hold_seen  = hold_req;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic push_draw(logic [WORD_W-1:0] word, logic restart);
        draw_req_t req;
        req.word    = word;
        req.restart = restart;
        pending_draws.push_back(req);
        queued_total++;
    endtask

    // register writes happen only while nothing is in flight
    task automatic set_config(pss_count_t pool, pss_count_t samples);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_POOL_SIZE;
        cfg_data  <= pool;
        @(posedge aclk);
        pool_size_reg = pool;
        @(negedge aclk);
        cfg_index <= CFG_SAMPLE_COUNT;
        cfg_data  <= samples;
        @(posedge aclk);
        sample_count_reg = samples;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_draws.size() != 0 || have_item || predicted_draws.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        pss_count_t  pool, samples;
        int unsigned runs, n;
        bit          noisy, first_restart;

        foreach (pool_mark[i]) pool_mark[i] = 1'b0;
        foreach (pool_tab[i]) pool_tab[i] = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset defaults, word extremes and alternating bit patterns
        push_draw('0, 1'b1);
        push_draw('1, 1'b0);
        push_draw(31'h2AAA_AAAA, 1'b0);
        push_draw(31'h5555_5555, 1'b0);
        wait_idle();

        // registers shrunk mid-run: count already past the new limit
        set_config(9'd3, 9'd2);
        push_draw(31'd7, 1'b0);
        push_draw(31'd5, 1'b1);
        push_draw('1, 1'b0);
        push_draw(31'd1, 1'b0);
        push_draw(31'd2, 1'b1);
        wait_idle();

        // zero pool, then zero sample count
        set_config(9'd0, 9'd5);
        push_draw(31'd9, 1'b1);
        push_draw(31'd9, 1'b0);
        wait_idle();
        set_config(9'd4, 9'd0);
        push_draw(31'd3, 1'b1);
        push_draw(31'd3, 1'b0);
        wait_idle();

        // pool above the table depth saturates
        set_config(9'd511, 9'd3);
        push_draw('1, 1'b1);
        push_draw(31'd255, 1'b0);
        push_draw(31'd256, 1'b0);
        push_draw(31'd0, 1'b0);
        wait_idle();

        // sample count above pool: run ends with no last marker
        set_config(9'd2, 9'd511);
        push_draw(31'd1, 1'b1);
        push_draw(31'd0, 1'b0);
        push_draw(31'd4, 1'b0);
        wait_idle();

        // single-entry pool
        set_config(9'd1, 9'd1);
        push_draw('1, 1'b1);
        push_draw(31'd0, 1'b0);
        wait_idle();

        // receiver holds off while the sender keeps offering
        send_idle_max = 0;
        recv_idle_max = 0;
        set_config(9'd16, 9'd16);
        @(negedge aclk);
        hold_req = ~hold_req;
        for (int unsigned k = 0; k < 16; k++) push_draw(rand_word(), k == 0);
        wait_idle();

        // restart on every item, enough to wrap the run tag
        send_idle_max = 2;
        recv_idle_max = 2;
        set_config(9'($urandom_range(1, 8)), 9'($urandom_range(1, 8)));
        for (int unsigned k = 0; k < STORM_ITEMS; k++) push_draw(rand_word(), 1'b1);
        wait_idle();

        // random phases of mostly well-formed runs
        while (queued_total < ITEM_TARGET) begin
            case ($urandom_range(0, 19))
                0:       pool = 9'd0;
                1:       pool = 9'($urandom_range(257, 511));
                2:       pool = 9'd256;
                3, 4, 5: pool = 9'($urandom_range(17, 255));
                default: pool = 9'($urandom_range(1, 16));
            endcase
            case ($urandom_range(0, 19))
                0:       samples = 9'd0;
                1:       samples = 9'($urandom_range(257, 511));
                2:       samples = 9'd256;
                3:       samples = 9'd1;
                default: samples = 9'($urandom_range(1, 20));
            endcase
            send_idle_max = pick_idle();
            recv_idle_max = pick_idle();
            set_config(pool, samples);
            runs  = $urandom_range(1, 4);
            noisy = ($urandom_range(0, 3) == 0);
            for (int unsigned r = 0; r < runs; r++) begin
                // sometimes carry the old run into the new settings
                first_restart = !(r == 0 && $urandom_range(0, 3) == 0);
                n = run_limit() + $urandom_range(0, 2);
                for (int unsigned k = 0; k < n && queued_total < ITEM_TARGET; k++)
                    push_draw(rand_word(),
                              (k == 0) ? first_restart : (noisy && $urandom_range(0, 7) == 0));
            end
            wait_idle();
        end

        // drain and watch for stray results
        wait_idle();
        repeat (60) @(posedge aclk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/pss_pkg.sv
src/pss_mod_unit.sv
src/pss_pool_mem.sv
src/partial_shuffle_sampler_core.sv
dv/testbench.sv
